@@ hdl/midi_note_to_led_color_top_defines.svh @@
// Assertion helpers for the RTL files; only mnlc_back includes them.
`ifndef MIDI_NOTE_TO_LED_COLOR_TOP_DEFINES_SVH
`define MIDI_NOTE_TO_LED_COLOR_TOP_DEFINES_SVH

// Checked on every clock edge once reset is released.
`define MNLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, during reset too.
`define MNLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hdl/mnlc_pkg.sv @@
package mnlc_pkg;

  localparam logic [7:0] StNoteOn  = 8'h90;
  localparam logic [7:0] StNoteOff = 8'h80;

  // completed note-on, as handed from parser to LED engine
  typedef struct packed {
    logic [3:0] hue;
    logic [7:0] gidx;
  } note_msg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CALC,
    B_EMIT
  } back_state_e;

  localparam logic [7:0] GammaLut [256] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2,
    8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd5,
    8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8,
    8'd8, 8'd9, 8'd9, 8'd9, 8'd10, 8'd10, 8'd11, 8'd11,
    8'd11, 8'd12, 8'd12, 8'd13, 8'd13, 8'd13, 8'd14, 8'd14,
    8'd15, 8'd15, 8'd16, 8'd16, 8'd17, 8'd17, 8'd18, 8'd18,
    8'd19, 8'd19, 8'd20, 8'd21, 8'd21, 8'd22, 8'd22, 8'd23,
    8'd23, 8'd24, 8'd25, 8'd25, 8'd26, 8'd27, 8'd27, 8'd28,
    8'd29, 8'd29, 8'd30, 8'd31, 8'd31, 8'd32, 8'd33, 8'd34,
    8'd34, 8'd35, 8'd36, 8'd37, 8'd37, 8'd38, 8'd39, 8'd40,
    8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd46,
    8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54,
    8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
    8'd63, 8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70,
    8'd71, 8'd72, 8'd73, 8'd74, 8'd76, 8'd77, 8'd78, 8'd79,
    8'd80, 8'd81, 8'd83, 8'd84, 8'd85, 8'd86, 8'd88, 8'd89,
    8'd90, 8'd91, 8'd93, 8'd94, 8'd95, 8'd96, 8'd98, 8'd99,
    8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd109, 8'd110,
    8'd111, 8'd113, 8'd114, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121,
    8'd123, 8'd124, 8'd126, 8'd128, 8'd129, 8'd131, 8'd132, 8'd134,
    8'd135, 8'd137, 8'd138, 8'd140, 8'd142, 8'd143, 8'd145, 8'd146,
    8'd148, 8'd150, 8'd151, 8'd153, 8'd155, 8'd157, 8'd158, 8'd160,
    8'd162, 8'd163, 8'd165, 8'd167, 8'd169, 8'd170, 8'd172, 8'd174,
    8'd176, 8'd178, 8'd179, 8'd181, 8'd183, 8'd185, 8'd187, 8'd189,
    8'd191, 8'd193, 8'd194, 8'd196, 8'd198, 8'd200, 8'd202, 8'd204,
    8'd206, 8'd208, 8'd210, 8'd212, 8'd214, 8'd216, 8'd218, 8'd220,
    8'd222, 8'd224, 8'd227, 8'd229, 8'd231, 8'd233, 8'd235, 8'd237,
    8'd239, 8'd241, 8'd244, 8'd246, 8'd248, 8'd250, 8'd252, 8'd255
  };

  // base color of a hue, packed {r, g, b}
  function automatic logic [23:0] hue_rgb(input logic [3:0] hue);
    logic [23:0] rgb;
    unique case (hue)
      4'd0:    rgb = {8'd255, 8'd0,   8'd0};
      4'd1:    rgb = {8'd255, 8'd127, 8'd0};
      4'd2:    rgb = {8'd255, 8'd255, 8'd0};
      4'd3:    rgb = {8'd127, 8'd255, 8'd0};
      4'd4:    rgb = {8'd0,   8'd255, 8'd0};
      4'd5:    rgb = {8'd0,   8'd255, 8'd127};
      4'd6:    rgb = {8'd0,   8'd255, 8'd255};
      4'd7:    rgb = {8'd0,   8'd127, 8'd255};
      4'd8:    rgb = {8'd0,   8'd0,   8'd255};
      4'd9:    rgb = {8'd127, 8'd0,   8'd255};
      4'd10:   rgb = {8'd255, 8'd0,   8'd255};
      4'd11:   rgb = {8'd255, 8'd0,   8'd127};
      default: rgb = 24'd0;
    endcase
    return rgb;
  endfunction

  // floor(c*g/255): exact for 8-bit by 8-bit products via (x + (x>>8) + 1) >> 8
  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] g);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = c * g;
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

@@ hdl/mnlc_front.sv @@
module mnlc_front import mnlc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output note_msg_t  push_msg_o
);

  logic [1:0]  bytes_left_q, bytes_left_d;
  logic        note_on_q, note_on_d;
  logic [7:0]  held_note_q, held_note_d;
  logic        acc;
  logic [15:0] quot_prod;
  logic [7:0]  rem;

  assign rx_ready_o = !q_full_i;
  assign acc        = rx_valid_i && rx_ready_o;

  // note mod 12: quotient by multiply with 171/2048, exact for 8-bit notes
  assign quot_prod = held_note_q * 8'd171;
  assign rem       = held_note_q - 8'(quot_prod[15:11] * 4'd12);

  always_comb begin
    bytes_left_d = bytes_left_q;
    note_on_d    = note_on_q;
    held_note_d  = held_note_q;
    push_o       = 1'b0;
    if (acc) begin
      priority if (rx_byte_i == StNoteOn || rx_byte_i == StNoteOff) begin
        note_on_d    = (rx_byte_i == StNoteOn);
        bytes_left_d = 2'd2;
      end else if (bytes_left_q == 2'd2) begin
        held_note_d  = rx_byte_i;
        bytes_left_d = 2'd1;
      end else if (bytes_left_q == 2'd1) begin
        bytes_left_d = 2'd0;
        push_o       = note_on_q;
      end else begin
        bytes_left_d = 2'd0;
      end
    end
  end

  assign push_msg_o.hue  = rem[3:0];
  assign push_msg_o.gidx = {rx_byte_i[6:0], 1'b0} + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 2'd0;
      note_on_q    <= 1'b0;
      held_note_q  <= 8'd0;
    end else begin
      bytes_left_q <= bytes_left_d;
      note_on_q    <= note_on_d;
      held_note_q  <= held_note_d;
    end
  end

endmodule

@@ hdl/mnlc_queue.sv @@
module mnlc_queue import mnlc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  note_msg_t push_msg_i,
  input  logic      pop_i,
  output note_msg_t pop_msg_o,
  output logic      full_o,
  output logic      empty_o
);

  note_msg_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_msg_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_msg_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ hdl/mnlc_back.sv @@
`include "midi_note_to_led_color_top_defines.svh"

module mnlc_back import mnlc_pkg::*; #(
  parameter int unsigned MAX_LEDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        q_empty_i,
  input  note_msg_t   q_msg_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] grb_word_o,
  output logic [3:0]  led_index_o,
  output logic        last_led_o
);

  localparam int unsigned LimInt = (MAX_LEDS < 16) ? MAX_LEDS : 16;
  localparam logic [4:0]  LedLim = 5'(LimInt);

  back_state_e state_q, state_d;
  logic [4:0]  led_count_q;
  logic [4:0]  n_q;
  logic [3:0]  hue_q;
  logic [7:0]  gamma_q;
  logic [23:0] color_q;
  logic [3:0]  idx_q;
  logic        out_valid_q;
  logic [23:0] grb_q;
  logic [3:0]  oidx_q;
  logic        olast_q;
  logic [23:0] rgb;
  logic        slot_free;
  logic        load_out;
  logic        is_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_last   = ({1'b0, idx_q} + 5'd1 == n_q);
  assign rgb       = hue_rgb(hue_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!q_empty_i) state_d = B_CALC;
      B_CALC:  state_d = (n_q == 5'd0) ? B_IDLE : B_EMIT;
      B_EMIT:  if (slot_free && is_last) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == B_IDLE) && !q_empty_i;
    load_out = (state_q == B_EMIT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      led_count_q <= 5'd4;
      out_valid_q <= 1'b0;
      idx_q       <= 4'd0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) led_count_q <= cfg_wdata_i;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == B_CALC) idx_q <= 4'd0;
      else if (load_out) idx_q <= idx_q + 4'd1;
    end
  end

  // payload: message fields, scaled color, output word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hue_q   <= q_msg_i.hue;
      gamma_q <= GammaLut[q_msg_i.gidx];
      n_q     <= (led_count_q > LedLim) ? LedLim : led_count_q;
    end
    if (state_q == B_CALC) begin
      color_q <= {scale_chan(rgb[15:8], gamma_q),
                  scale_chan(rgb[23:16], gamma_q),
                  scale_chan(rgb[7:0], gamma_q)};
    end
    if (load_out) begin
      grb_q   <= color_q;
      oidx_q  <= idx_q;
      olast_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign grb_word_o  = grb_q;
  assign led_index_o = oidx_q;
  assign last_led_o  = olast_q;

  `MNLC_ASSERT(a_emit_nonzero, (state_q == B_EMIT) |-> (n_q != 5'd0), "emit with zero count")
  `MNLC_ASSERT(a_idx_in_range, (state_q == B_EMIT) |-> ({1'b0, idx_q} < n_q), "index past count")
  `MNLC_ASSERT(a_calc_once, (state_q == B_CALC) |=> (state_q != B_CALC), "calc held over")
  `MNLC_ASSERT_ALWAYS(a_pop_idle, pop_o |-> (state_q == B_IDLE), "pop outside idle")

endmodule

@@ hdl/midi_note_to_led_color_top.sv @@
// MIDI note-on to GRB LED word converter.
// Input channel rx_*: one received MIDI byte per transfer. 0x90 / 0x80 open a
// three-byte note-on / note-off message; stray bytes outside a message are dropped.
// Output channel out_*: on a completed note-on, led_count transfers of the same
// 24-bit GRB word, led_index counting from 0, last_led set on the final one.
// Note-off and a zero led_count produce nothing.
// Config: cfg_we_i writes led_count (reset 4, saturated to min(MAX_LEDS,16)).
// Structure: parser front -> 2-entry message queue -> color/emit engine.
// Throughput: the parser takes one byte per cycle while the queue has room;
// the engine takes each note through a gamma lookup and channel scaling, then
// one word per cycle while out_ready_i is high, set by its single output register.
// First word path: queue entry, lookup registers, scaled color, output register.
// A stalled receiver holds the output word; the engine waits, then the queue
// fills, and only then rx_ready_o drops.
// Reset (async, active low) clears parser state, queue and engine, and sets
// led_count back to 4.
module midi_note_to_led_color_top import mnlc_pkg::*; #(
  parameter int unsigned MAX_LEDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] grb_word_o,
  output logic [3:0]  led_index_o,
  output logic        last_led_o
);

  logic      push, pop, q_full, q_empty;
  note_msg_t push_msg, pop_msg;

  mnlc_front u_front (
    .clk_i,
    .rst_ni,
    .rx_valid_i,
    .rx_ready_o,
    .rx_byte_i,
    .q_full_i   (q_full),
    .push_o     (push),
    .push_msg_o (push_msg)
  );

  mnlc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_msg_i (push_msg),
    .pop_i      (pop),
    .pop_msg_o  (pop_msg),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  mnlc_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .q_empty_i  (q_empty),
    .q_msg_i    (pop_msg),
    .pop_o      (pop),
    .out_valid_o,
    .out_ready_i,
    .grb_word_o,
    .led_index_o,
    .last_led_o
  );

endmodule
